// File: rtl/hrla_pkg.sv
`default_nettype none

package hrla_pkg;

    // Size of the receive line buffer in bytes.
    localparam int LINE_BUFFER_BYTES = 2048;
    localparam int COUNT_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(LINE_BUFFER_BYTES - 1);

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_START = 2'd1,
        KIND_CLOSE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_PENDING = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_REJECT  = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_PATH   = 3'd1,
        PH_QUERY  = 3'd2,
        PH_SPACES = 3'd3,
        PH_PROTO  = 3'd4,
        PH_TAIL   = 3'd5,
        PH_BAD    = 3'd6
    } t_phase;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;

    localparam logic [2:0] NAME_FULL = 3'd4;
    localparam logic [2:0] NAME_DEAD = 3'd5;
    localparam logic [3:0] PROTO_FIXED = 4'd7;
    localparam logic [3:0] PROTO_LEN   = 4'd8;

    // "GET "
    function automatic logic [7:0] method_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h45;
            2'd2:    c = 8'h54;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    // "HTTP/1." ; the last version digit is checked apart
    function automatic logic [7:0] proto_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h54;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h50;
            4'd4:    c = 8'h2F;
            4'd5:    c = 8'h31;
            default: c = 8'h2E;
        endcase
        return c;
    endfunction

    // "cnew"
    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h6E;
            3'd2:    c = 8'h65;
            default: c = 8'h77;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hrla_parser.sv
`default_nettype none

module hrla_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_data_byte,
    output logic      [1:0] o_verdict
);

    hrla_pkg::t_phase                r_phase, n_phase;
    logic [1:0]                      r_mpos, n_mpos;
    logic [hrla_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [2:0]                      r_name, n_name;
    logic                            r_in_value, n_in_value;
    logic                            r_key, n_key;
    logic [3:0]                      r_ppos, n_ppos;
    hrla_pkg::t_verdict              r_verdict, n_verdict;

    logic                            w_count;
    logic                            w_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hrla_pkg::PH_METHOD;
            r_mpos     <= '0;
            r_count    <= '0;
            r_name     <= '0;
            r_in_value <= 1'b0;
            r_key      <= 1'b0;
            r_ppos     <= '0;
            r_verdict  <= hrla_pkg::VERDICT_PENDING;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_mpos     <= n_mpos;
            r_count    <= n_count;
            r_name     <= n_name;
            r_in_value <= n_in_value;
            r_key      <= n_key;
            r_ppos     <= n_ppos;
            r_verdict  <= n_verdict;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_mpos     = r_mpos;
        n_count    = r_count;
        n_name     = r_name;
        n_in_value = r_in_value;
        n_key      = r_key;
        n_ppos     = r_ppos;
        n_verdict  = r_verdict;
        w_count    = 1'b0;
        w_ok       = 1'b0;

        if (i_kind == hrla_pkg::KIND_START) begin
            n_phase    = hrla_pkg::PH_METHOD;
            n_mpos     = '0;
            n_count    = '0;
            n_name     = '0;
            n_in_value = 1'b0;
            n_key      = 1'b0;
            n_ppos     = '0;
            n_verdict  = hrla_pkg::VERDICT_PENDING;
        end else if (r_verdict == hrla_pkg::VERDICT_PENDING) begin
            if (i_kind == hrla_pkg::KIND_CLOSE) begin
                n_verdict = hrla_pkg::VERDICT_REJECT;
            end else if (i_kind == hrla_pkg::KIND_DATA) begin
                if (r_phase == hrla_pkg::PH_METHOD) begin
                    if (i_data_byte != hrla_pkg::method_char(r_mpos)) begin
                        n_verdict = hrla_pkg::VERDICT_REJECT;
                    end else begin
                        n_mpos  = r_mpos + 2'd1;
                        w_count = 1'b1;
                        if (r_mpos == 2'd3) begin
                            n_phase = hrla_pkg::PH_PATH;
                        end
                    end
                end else if (i_data_byte == hrla_pkg::CH_NEWLINE) begin
                    // settle the line
                    if (r_phase == hrla_pkg::PH_TAIL && r_key) begin
                        n_verdict = hrla_pkg::VERDICT_ACCEPT;
                    end else begin
                        n_verdict = hrla_pkg::VERDICT_REJECT;
                    end
                end else begin
                    w_count = 1'b1;
                    case (r_phase)
                        hrla_pkg::PH_PATH: begin
                            if (i_data_byte == hrla_pkg::CH_SPACE) begin
                                n_phase = hrla_pkg::PH_SPACES;
                            end else if (i_data_byte == hrla_pkg::CH_QUEST) begin
                                n_phase = hrla_pkg::PH_QUERY;
                            end
                        end
                        hrla_pkg::PH_QUERY: begin
                            if (i_data_byte == hrla_pkg::CH_SPACE) begin
                                if (!r_in_value && r_name == hrla_pkg::NAME_FULL) begin
                                    n_key = 1'b1;
                                end
                                n_phase = hrla_pkg::PH_SPACES;
                            end else if (i_data_byte == hrla_pkg::CH_AMP) begin
                                if (!r_in_value && r_name == hrla_pkg::NAME_FULL) begin
                                    n_key = 1'b1;
                                end
                                n_name     = '0;
                                n_in_value = 1'b0;
                            end else if (i_data_byte == hrla_pkg::CH_EQUAL) begin
                                if (!r_in_value) begin
                                    if (r_name == hrla_pkg::NAME_FULL) begin
                                        n_key = 1'b1;
                                    end
                                    n_in_value = 1'b1;
                                end
                            end else if (!r_in_value) begin
                                if (r_name < hrla_pkg::NAME_FULL &&
                                    i_data_byte == hrla_pkg::key_char(r_name)) begin
                                    n_name = r_name + 3'd1;
                                end else begin
                                    n_name = hrla_pkg::NAME_DEAD;
                                end
                            end
                        end
                        hrla_pkg::PH_SPACES, hrla_pkg::PH_PROTO: begin
                            if (!(r_phase == hrla_pkg::PH_SPACES &&
                                  i_data_byte == hrla_pkg::CH_SPACE)) begin
                                if (r_ppos < hrla_pkg::PROTO_FIXED) begin
                                    w_ok = (i_data_byte == hrla_pkg::proto_char(r_ppos));
                                end else begin
                                    w_ok = (i_data_byte == hrla_pkg::CH_ZERO) ||
                                           (i_data_byte == hrla_pkg::CH_ONE);
                                end
                                if (!w_ok) begin
                                    n_phase = hrla_pkg::PH_BAD;
                                end else begin
                                    n_ppos = r_ppos + 4'd1;
                                    if (r_ppos + 4'd1 >= hrla_pkg::PROTO_LEN) begin
                                        n_phase = hrla_pkg::PH_TAIL;
                                    end else begin
                                        n_phase = hrla_pkg::PH_PROTO;
                                    end
                                end
                            end
                        end
                        default: begin
                            // tail and bad phases: drop bytes until newline
                        end
                    endcase
                end

                if (w_count) begin
                    if (r_count >= hrla_pkg::COUNT_LAST) begin
                        n_verdict = hrla_pkg::VERDICT_REJECT;
                    end else begin
                        n_count = r_count + hrla_pkg::COUNT_W'(1);
                    end
                end
            end
        end
    end

    assign o_verdict = n_verdict;

endmodule

`default_nettype wire

// File: rtl/http_request_line_admission.sv
// HTTP request line admission check.
//
// Input channel (i_valid / o_ready): one transaction per received item.
// i_kind selects a data byte (i_data_byte), the start of a new connection
// (clears all parse state) or the peer closing the connection.
// Output channel (o_valid / i_ready): exactly one transaction per input
// transaction, carrying the running verdict (pending, accepted, rejected).
// Once accepted or rejected, the verdict holds until the next start item.
//
// A transaction accepted by the block lands in the input register; its
// verdict is written to the output register when the item moves on, and
// o_valid is driven from that output register.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the combinational parse step between the input and output registers.
//
// Reset (synchronous, active low) empties both registers and puts the
// parser in the method phase with a pending verdict.
// When the receiver stalls, the output register holds its verdict and the
// input register still takes one more transaction; after that o_ready
// drops until the output side moves again. Nothing is lost or repeated.
`default_nettype none

module http_request_line_admission (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic      [1:0] o_verdict
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_kind;
    logic [7:0] r_in_byte;

    // output register
    logic       r_out_valid;
    logic [1:0] r_out_verdict;

    logic       w_advance;
    logic       w_step;
    logic       w_take;
    logic [1:0] w_verdict;

    // advance the pipeline whenever the output slot is free or being drained
    assign w_advance = !r_out_valid || i_ready;
    assign w_step    = r_in_valid && w_advance;
    assign o_ready   = !r_in_valid || w_advance;
    assign w_take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_data_byte;
        end
    end

    // parse state advances only when the item moves into the output register
    hrla_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_kind      (r_in_kind),
        .i_data_byte (r_in_byte),
        .o_verdict   (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_verdict <= w_verdict;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;

endmodule

`default_nettype wire

// File: tb/sv/tb_http_request_line_admission.sv
`timescale 1ns / 100ps

module tb_http_request_line_admission;

    import hrla_pkg::*;

    // The block has no name for the unused kind code; it must be ignored.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Cycles with no transaction on either side before the run is given up.
    localparam int STALL_LIMIT = 400;

    // Tracks one connection the way the block should and holds the verdicts
    // still owed by the output channel, oldest first.
    class admission_tracker;
        t_phase     phase;
        logic [2:0] meth_pos;
        logic [11:0] line_count;
        logic [2:0] name_pos;
        bit         in_value;
        bit         key_seen;
        logic [3:0] proto_pos;
        t_verdict   verdict;
        t_verdict   verdicts_due[$];
        int         mismatches;
        string      method_txt = "GET ";
        string      proto_txt  = "HTTP/1.";
        string      key_txt    = "cnew";

        function new();
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase      = PH_METHOD;
            meth_pos   = '0;
            line_count = '0;
            name_pos   = '0;
            in_value   = 1'b0;
            key_seen   = 1'b0;
            proto_pos  = '0;
            verdict    = VERDICT_PENDING;
        endfunction

        function void close_name();
            if (!in_value && name_pos == NAME_FULL)
                key_seen = 1'b1;
        endfunction

        function void query_in(input logic [7:0] c);
            if (c == CH_AMP) begin
                close_name();
                name_pos = '0;
                in_value = 1'b0;
            end else if (c == CH_EQUAL) begin
                if (!in_value) begin
                    close_name();
                    in_value = 1'b1;
                end
            end else if (!in_value) begin
                if (name_pos < NAME_FULL && c == 8'(key_txt[name_pos]))
                    name_pos++;
                else
                    name_pos = NAME_DEAD;
            end
        endfunction

        function void byte_in(input logic [7:0] c);
            bit ok;
            if (phase == PH_METHOD) begin
                if (meth_pos > 3'd3 || c != 8'(method_txt[meth_pos])) begin
                    verdict = VERDICT_REJECT;
                    return;
                end
                meth_pos++;
                if (meth_pos == 3'd4)
                    phase = PH_PATH;
            end else if (c == CH_NEWLINE) begin
                verdict = (phase == PH_TAIL && key_seen) ? VERDICT_ACCEPT : VERDICT_REJECT;
                return;
            end else if (phase == PH_PATH) begin
                if (c == CH_SPACE)
                    phase = PH_SPACES;
                else if (c == CH_QUEST)
                    phase = PH_QUERY;
            end else if (phase == PH_QUERY) begin
                if (c == CH_SPACE) begin
                    close_name();
                    phase = PH_SPACES;
                end else begin
                    query_in(c);
                end
            end else if (phase == PH_SPACES || phase == PH_PROTO) begin
                if (!(phase == PH_SPACES && c == CH_SPACE)) begin
                    if (proto_pos < PROTO_FIXED)
                        ok = (c == 8'(proto_txt[proto_pos]));
                    else
                        ok = (c == CH_ZERO || c == CH_ONE);
                    if (!ok) begin
                        phase = PH_BAD;
                    end else begin
                        proto_pos++;
                        phase = (proto_pos >= PROTO_LEN) ? PH_TAIL : PH_PROTO;
                    end
                end
            end
            if (int'(line_count) + 1 >= LINE_BUFFER_BYTES)
                verdict = VERDICT_REJECT;
            else
                line_count++;
        endfunction

        function void take_item(input logic [1:0] kind, input logic [7:0] c);
            if (kind == KIND_START) begin
                clear_line();
            end else if (verdict == VERDICT_PENDING) begin
                if (kind == KIND_DATA)
                    byte_in(c);
                else if (kind == KIND_CLOSE)
                    verdict = VERDICT_REJECT;
            end
            verdicts_due = {verdicts_due, verdict};
        endfunction

        function void check_verdict(input logic [1:0] got);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                $error("verdict: expected none, got %0d", got);
                mismatches++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want) begin
                $error("verdict: expected %0d, got %0d", want, got);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [1:0] i_kind      = KIND_DATA;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_verdict;

    admission_tracker tracker;

    int burst_left  = 0;
    int items_sent  = 0;
    int idle_cycles = 0;
    logic [7:0] req_bytes[$];

    http_request_line_admission uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_verdict   (o_verdict)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Sample both channels with the values seen before the edge: note every
    // accepted input transaction, then check every accepted verdict.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                tracker.take_item(i_kind, i_data_byte);
            if (o_valid && i_ready)
                tracker.check_verdict(o_verdict);
        end
    end

    // Give up when neither side has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_http_request_line_admission NOT OK");
                $finish;
            end
        end
    end

    // Receiver back-pressure: switch between segments that are always ready,
    // ready at random, and long alternating stall/ready runs.
    int rx_mode  = 0;
    int rx_seg   = 0;
    int rx_hold  = 0;
    bit rx_level = 1'b1;
    bit rx_next;

    always @(posedge i_clk) begin
        if (rx_seg == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_seg  = $urandom_range(16, 160);
        end else begin
            rx_seg--;
        end
        case (rx_mode)
            0: rx_next = 1'b1;
            1: rx_next = ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_hold == 0) begin
                    rx_level = !rx_level;
                    rx_hold  = rx_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
                end else begin
                    rx_hold--;
                end
                rx_next = rx_level;
            end
        endcase
        i_ready <= rx_next;
    end

    // Drive one transaction and hold it until accepted. The sender runs in
    // bursts; before each new burst, drop valid for a random gap (maybe none).
    task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic open_connection();
        send_item(KIND_START, 8'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(KIND_DATA, 8'(s[k]));
    endtask

    task automatic send_line();
        foreach (req_bytes[k])
            send_item(KIND_DATA, req_bytes[k]);
    endtask

    // Append one byte to the request line being built.
    function automatic void put_byte(input logic [7:0] b);
        req_bytes = {req_bytes, b};
    endfunction

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            put_byte(8'(s[k]));
    endfunction

    function automatic void put_rand_char();
        string pool;
        pool = "cnewCNW?&=/.1_x ";
        put_byte(8'(pool[$urandom_range(0, pool.len() - 1)]));
    endfunction

    function automatic void put_name();
        case ($urandom_range(0, 7))
            0, 1: put_text("cnew");
            2: put_text("cne");
            3: put_text("cnewx");
            4: put_text("xcnew");
            5: ; // empty name
            6: put_text("CNEW");
            default: repeat ($urandom_range(1, 4)) put_rand_char();
        endcase
    endfunction

    function automatic void put_value();
        case ($urandom_range(0, 5))
            0: ;
            1: put_text("1");
            2: put_text("cnew");
            3: put_text("a=b");
            4: put_text("x?y");
            default: repeat ($urandom_range(1, 4)) put_rand_char();
        endcase
    endfunction

    // Build a mostly well-formed request line with random content, then
    // corrupt, truncate or abandon it now and then.
    task automatic run_connection();
        int n_param;
        int cut;
        int ending;
        int idx;
        req_bytes.delete();
        open_connection();
        put_text("GET ");
        if ($urandom_range(0, 15) == 0)
            req_bytes[$urandom_range(0, 3)] = 8'($urandom);
        put_text("/");
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 19) == 0)
                put_byte(8'($urandom));
            else
                put_text("ab/.-");
            if ($urandom_range(0, 1) == 0)
                void'(req_bytes.pop_back());
        end
        if ($urandom_range(0, 4) != 0) begin
            put_text("?");
            n_param = $urandom_range(0, 3);
            for (int p = 0; p < n_param; p++) begin
                if (p > 0) begin
                    put_text("&");
                    if ($urandom_range(0, 7) == 0)
                        put_text("&");
                end
                put_name();
                if ($urandom_range(0, 2) != 0) begin
                    put_text("=");
                    put_value();
                end
            end
        end
        repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3))
            put_byte(CH_SPACE);
        put_text($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0");
        if ($urandom_range(0, 7) == 0) begin
            idx = req_bytes.size() - 1 - $urandom_range(0, 7);
            req_bytes[idx] = 8'($urandom);
        end
        repeat ($urandom_range(0, 3))
            put_byte(($urandom_range(0, 1) == 0) ? 8'h0D : 8'($urandom));

        ending = $urandom_range(0, 11);
        if (ending >= 8 && ending <= 10) begin
            cut = $urandom_range(0, req_bytes.size());
            while (req_bytes.size() > cut) void'(req_bytes.pop_back());
        end
        if (ending <= 8)
            put_byte(CH_NEWLINE);
        send_line();
        case (ending)
            9:  send_item(KIND_CLOSE, 8'($urandom));
            10: send_item(KIND_UNUSED, 8'($urandom));
            11: ; // leave the line pending into the next connection
            default: begin
                // anything after a final verdict must be ignored
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 2))
                        0: send_item(KIND_DATA, 8'($urandom));
                        1: send_item(KIND_CLOSE, 8'($urandom));
                        default: send_item(KIND_UNUSED, 8'($urandom));
                    endcase
                end
            end
        endcase
    endtask

    // Random kinds and full-range bytes, mostly data.
    task automatic run_noise();
        open_connection();
        repeat ($urandom_range(1, 16)) begin
            if ($urandom_range(0, 5) == 0)
                send_item(2'($urandom), 8'($urandom));
            else
                send_item(KIND_DATA, 8'($urandom));
        end
    endtask

    // A line whose length lands exactly on the buffer size: with the given
    // filler the newline, or the byte just before it, is the last byte that
    // fits.
    task automatic run_long_line(input int filler);
        req_bytes.delete();
        open_connection();
        put_text("GET /?cnew=");
        repeat (filler) put_text("v");
        put_text(" HTTP/1.1");
        put_byte(CH_NEWLINE);
        send_line();
    endtask

    initial begin
        int goal;
        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Accepted line straight after reset, with no start item; then trailing
        // data and a close that must not change the verdict.
        send_text("GET /?cnew HTTP/1.1\n");
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_CLOSE, 8'h00);
        // Skipped spaces, value on the key, tail bytes before the newline.
        open_connection();
        send_text("GET /a?x=1&cnew=2  HTTP/1.0 xx\n");
        // Wrong method byte rejects at once.
        open_connection();
        send_text("POST");
        // Newline in the URI, before the protocol, and mid-protocol.
        open_connection();
        send_text("GET /x\n");
        open_connection();
        send_text("GET / \n");
        open_connection();
        send_text("GET /?cnew HTTP/1\n");
        // Wrong protocol byte stays pending until the newline.
        open_connection();
        send_text("GET /?cnew HTTX/1.1\n");
        // Missing key.
        open_connection();
        send_text("GET /?cne HTTP/1.1\n");
        // Unused kind while pending, then peer close rejects.
        open_connection();
        send_text("GET /?c");
        send_item(KIND_UNUSED, 8'hA5);
        send_item(KIND_CLOSE, 8'h5A);
        // Buffer boundary: newline as the last byte that fits is evaluated,
        // a protocol byte in that place rejects.
        run_long_line(LINE_BUFFER_BYTES - 21);
        run_long_line(LINE_BUFFER_BYTES - 20);

        goal = items_sent + 600;
        while (items_sent < goal) begin
            if ($urandom_range(0, 4) == 0)
                run_noise();
            else
                run_connection();
        end
        i_valid <= 1'b0;

        // Drain the outstanding verdicts, then let the pipeline settle.
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("tb_http_request_line_admission OK");
        end else begin
            $display("tb_http_request_line_admission NOT OK");
        end
        $finish;
    end

endmodule
